### design/cjr_pkg.sv
// Shared types, codes and command-byte tables for the camera chunk reader.
// Used by every module of the block; depends on nothing.
`default_nettype none

package cjr_pkg;

    // Result kinds as seen on the output channel.
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_IMG  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // Input operations.
    localparam logic OP_START = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_FILE_SIZE   = 1'b0;
    localparam logic CFG_CHUNK_BYTES = 1'b1;

    localparam logic [15:0] FILE_SIZE_RESET   = 16'd0;
    localparam logic [15:0] CHUNK_BYTES_RESET = 16'd32;

    // Read command framing bytes.
    localparam logic [7:0] CMD_SYNC  = 8'h56;
    localparam logic [7:0] CMD_SERNO = 8'h00;
    localparam logic [7:0] CMD_READ  = 8'h32;
    localparam logic [7:0] CMD_LEN   = 8'h0C;
    localparam logic [7:0] CMD_MODE  = 8'h0A;
    localparam logic [7:0] CMD_DELAY = 8'h0A;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    // Acknowledge sequence 76 00 32 00 00.
    localparam logic [7:0] ACK_FIRST  = 8'h76;
    localparam logic [2:0] ACK_LENGTH = 3'd5;
    localparam logic [3:0] CMD_LAST_IDX = 4'd15;

    // Work handed from the control stage to the output stage.
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [15:0] offset;
        logic [15:0] addr;
        logic [15:0] len;
    } t_desc;

    // Expected byte at each position of the acknowledge.
    function automatic logic [7:0] ack_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = ACK_FIRST;
            3'd2:    b = CMD_READ;
            default: b = ZERO_BYTE;
        endcase
        return b;
    endfunction

    // One byte of the 16-byte read command.
    function automatic logic [7:0] cmd_byte(input logic [3:0] idx,
                                            input logic [15:0] addr,
                                            input logic [15:0] len);
        logic [7:0] b;
        case (idx)
            4'd0:    b = CMD_SYNC;
            4'd1:    b = CMD_SERNO;
            4'd2:    b = CMD_READ;
            4'd3:    b = CMD_LEN;
            4'd5:    b = CMD_MODE;
            4'd8:    b = addr[15:8];
            4'd9:    b = addr[7:0];
            4'd12:   b = len[15:8];
            4'd13:   b = len[7:0];
            4'd15:   b = CMD_DELAY;
            default: b = ZERO_BYTE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

### design/cjr_in_if.sv
// Input channel of the camera chunk reader: start items and received bytes.
// Stands alone; valid/ready handshake.
`default_nettype none

interface cjr_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

`default_nettype wire

### design/cjr_out_if.sv
// Output channel of the camera chunk reader: command bytes, image bytes, done.
// Stands alone; valid/ready handshake.
`default_nettype none

interface cjr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  byte_value;
    logic [15:0] image_offset;
    logic        last;

    modport source (output valid, output kind, output byte_value, output image_offset,
                    output last, input ready);
    modport sink   (input valid, input kind, input byte_value, input image_offset,
                    input last, output ready);
endinterface

`default_nettype wire

### design/camera_jpeg_chunk_reader.sv
// Camera chunk reader top level: ties the control stage to the output stage.
// Depends on cjr_pkg, cjr_in_if, cjr_out_if, cjr_ctrl and cjr_emit.
//
// Usage: the input channel carries words with an operation bit and a
// received byte. A start word (operation 0) sends a 16-byte read command
// for the next chunk, or a single done word if the file is empty. Byte
// words (operation 1) feed the camera's answer: the acknowledge is hunted,
// chunk bytes come out as image words with their file offset, and after
// the closing acknowledge the next command or the done word follows.
// Configuration (file size, chunk size) is to be written by the user through
// the plain write port while the block is idle; the block does not enforce it.
// A word's first result is registered and shows in the cycle after acceptance.
// Throughput: one word per cycle when results are taken at once; a word
// that issues a read command occupies the output register for its sixteen
// command bytes, one per cycle, and the next word is taken as the final
// byte leaves. When the receiver stalls, the output word holds and input
// ready drops until the held result is taken.
// Reset (synchronous, active low) clears all transfer state, empties the
// output register and restores the configuration defaults.
`default_nettype none

module camera_jpeg_chunk_reader (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    cjr_in_if.sink           i_in,
    cjr_out_if.source        o_out
);

    cjr_pkg::t_desc w_desc;
    logic           w_take;
    logic           w_in_fire;

    assign i_in.ready = w_take;
    assign w_in_fire  = i_in.valid && w_take;

    cjr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_fire   (w_in_fire),
        .i_operation (i_in.operation),
        .i_rx_byte   (i_in.rx_byte),
        .o_desc      (w_desc)
    );

    cjr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (w_desc),
        .i_out_ready (o_out.ready),
        .o_take      (w_take),
        .o_valid     (o_out.valid),
        .o_kind      (o_out.kind),
        .o_byte      (o_out.byte_value),
        .o_offset    (o_out.image_offset),
        .o_last      (o_out.last)
    );

    // No new word is taken while a command is still being played out.
    a_cmd_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == cjr_pkg::KIND_CMD && !o_out.last) |-> !i_in.ready)
        else $error("input taken in the middle of a read command");

    // A taken word that is not the last of its group is followed by another.
    a_group_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last) |=> o_out.valid)
        else $error("result group cut short");

    // Image and done words each stand alone.
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind != cjr_pkg::KIND_CMD) |-> o_out.last)
        else $error("image or done word without last");

endmodule

`default_nettype wire

### design/cjr_ctrl.sv
// Control stage: configuration registers, transfer state and acknowledge hunt.
// Depends on cjr_pkg; emits one descriptor per accepted word that has results.
`default_nettype none

module cjr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_in_fire,
    input  wire logic          i_operation,
    input  wire logic [7:0]    i_rx_byte,
    output cjr_pkg::t_desc     o_desc
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ACK1,
        PH_DATA,
        PH_ACK2
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_file_size, r_chunk_bytes;
    logic [15:0] r_read_addr, n_read_addr;
    logic [15:0] r_left_file, n_left_file;
    logic [15:0] r_left_chunk, n_left_chunk;
    logic [2:0]  r_ack_cnt, n_ack_cnt;
    logic [15:0] r_offset, n_offset;

    logic [2:0]  w_ack_idx, w_hunt_cnt;
    logic        w_hunt_hit;
    logic [15:0] w_send_left, w_chunk, w_len;
    logic [15:0] w_left_file_dec, w_left_chunk_dec;

    // Acknowledge hunt: a mismatch may still start a new match.
    always_comb begin
        w_ack_idx = (r_ack_cnt < cjr_pkg::ACK_LENGTH) ? r_ack_cnt : 3'd0;
        if (i_rx_byte == cjr_pkg::ack_byte(w_ack_idx)) begin
            w_hunt_cnt = w_ack_idx + 3'd1;
        end else begin
            w_hunt_cnt = (i_rx_byte == cjr_pkg::ACK_FIRST) ? 3'd1 : 3'd0;
        end
        w_hunt_hit = (w_hunt_cnt == cjr_pkg::ACK_LENGTH);
    end

    // Length of the next chunk: a start reloads the file length first.
    always_comb begin
        w_send_left = (i_operation == cjr_pkg::OP_START) ? r_file_size : r_left_file;
        w_chunk     = (r_chunk_bytes == 16'd0) ? 16'd1 : r_chunk_bytes;
        w_len       = (w_send_left < w_chunk) ? w_send_left : w_chunk;
        w_left_file_dec  = (r_left_file  != 16'd0) ? r_left_file  - 16'd1 : 16'd0;
        w_left_chunk_dec = (r_left_chunk != 16'd0) ? r_left_chunk - 16'd1 : 16'd0;
    end

    // Next state and descriptor for one accepted word.
    always_comb begin
        logic do_send;
        do_send      = 1'b0;
        n_phase      = r_phase;
        n_read_addr  = r_read_addr;
        n_left_file  = r_left_file;
        n_left_chunk = r_left_chunk;
        n_ack_cnt    = r_ack_cnt;
        n_offset     = r_offset;
        o_desc       = '0;

        if (i_operation == cjr_pkg::OP_START) begin
            n_left_file = r_file_size;
            n_offset    = 16'd0;
            n_ack_cnt   = 3'd0;
            do_send     = 1'b1;
        end else begin
            case (r_phase)
                PH_ACK1: begin
                    n_ack_cnt = w_hunt_hit ? 3'd0 : w_hunt_cnt;
                    if (w_hunt_hit) begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    o_desc.valid  = 1'b1;
                    o_desc.kind   = cjr_pkg::KIND_IMG;
                    o_desc.data   = i_rx_byte;
                    o_desc.offset = r_offset;
                    n_offset      = r_offset + 16'd1;
                    n_left_file   = w_left_file_dec;
                    n_left_chunk  = w_left_chunk_dec;
                    if (w_left_chunk_dec == 16'd0) begin
                        n_ack_cnt = 3'd0;
                        n_phase   = PH_ACK2;
                    end
                end
                PH_ACK2: begin
                    n_ack_cnt = w_hunt_hit ? 3'd0 : w_hunt_cnt;
                    do_send   = w_hunt_hit;
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // Either the next read command or the end of the file.
        if (do_send) begin
            o_desc.valid = 1'b1;
            if (w_send_left == 16'd0) begin
                o_desc.kind = cjr_pkg::KIND_DONE;
                n_phase     = PH_IDLE;
            end else begin
                o_desc.kind  = cjr_pkg::KIND_CMD;
                o_desc.addr  = r_read_addr;
                o_desc.len   = w_len;
                n_read_addr  = r_read_addr + w_len;
                n_left_chunk = w_len;
                n_ack_cnt    = 3'd0;
                n_phase      = PH_ACK1;
            end
        end

        if (!i_in_fire) begin
            o_desc.valid = 1'b0;
        end
    end

    // State and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_file_size   <= cjr_pkg::FILE_SIZE_RESET;
            r_chunk_bytes <= cjr_pkg::CHUNK_BYTES_RESET;
            r_read_addr   <= 16'd0;
            r_left_file   <= 16'd0;
            r_left_chunk  <= 16'd0;
            r_ack_cnt     <= 3'd0;
            r_offset      <= 16'd0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == cjr_pkg::CFG_FILE_SIZE) begin
                    r_file_size <= i_cfg_data;
                end else begin
                    r_chunk_bytes <= i_cfg_data;
                end
            end
            if (i_in_fire) begin
                r_phase      <= n_phase;
                r_read_addr  <= n_read_addr;
                r_left_file  <= n_left_file;
                r_left_chunk <= n_left_chunk;
                r_ack_cnt    <= n_ack_cnt;
                r_offset     <= n_offset;
            end
        end
    end

endmodule

`default_nettype wire

### design/cjr_emit.sv
// Output stage: holds one descriptor and plays it out as one or sixteen words.
// Depends on cjr_pkg for the descriptor type and command-byte table.
`default_nettype none

module cjr_emit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cjr_pkg::t_desc i_desc,
    input  wire logic          i_out_ready,
    output logic               o_take,
    output logic               o_valid,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_byte,
    output logic [15:0]        o_offset,
    output logic               o_last
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_data;
    logic [15:0] r_offset, r_addr, r_len;
    logic [3:0]  r_idx;
    logic        w_fire;

    // Word currently presented; a command walks through its sixteen bytes.
    always_comb begin
        o_valid  = r_valid;
        o_kind   = r_kind;
        o_offset = r_offset;
        if (r_kind == cjr_pkg::KIND_CMD) begin
            o_byte = cjr_pkg::cmd_byte(r_idx, r_addr, r_len);
            o_last = (r_idx == cjr_pkg::CMD_LAST_IDX);
        end else begin
            o_byte = r_data;
            o_last = 1'b1;
        end
        w_fire = r_valid && i_out_ready;
        o_take = !r_valid || (w_fire && o_last);
    end

    // Descriptor register and byte index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 4'd0;
        end else if (o_take) begin
            r_valid <= i_desc.valid;
            r_idx   <= 4'd0;
        end else if (w_fire) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_take && i_desc.valid) begin
            r_kind   <= i_desc.kind;
            r_data   <= i_desc.data;
            r_offset <= i_desc.offset;
            r_addr   <= i_desc.addr;
            r_len    <= i_desc.len;
        end
    end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench for camera_jpeg_chunk_reader: directed and random words on the
// input channel, with every result checked against a built-in predictor of the reader.
// Depends on cjr_pkg, cjr_in_if, cjr_out_if and the camera_jpeg_chunk_reader RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_WORDS    = 110;

    // The acknowledge 76 00 32 00 00, first byte in the top lane.
    localparam logic [39:0] ACK_WORD = {cjr_pkg::ACK_FIRST, cjr_pkg::ZERO_BYTE,
                                        cjr_pkg::CMD_READ, cjr_pkg::ZERO_BYTE,
                                        cjr_pkg::ZERO_BYTE};

    typedef enum logic [2:0] {RD_IDLE, RD_ACK1, RD_DATA, RD_ACK2} t_rd_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  value;
        logic [15:0] offset;
        logic        last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    cjr_in_if  in_ch ();
    cjr_out_if out_ch ();

    camera_jpeg_chunk_reader dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predicted reader state and configuration.
    logic [15:0] cfg_file_size;
    logic [15:0] cfg_chunk_bytes;
    t_rd_phase   rd_phase;
    logic [15:0] rd_addr;
    logic [15:0] file_left;
    logic [15:0] chunk_left;
    logic [15:0] chunk_len;
    logic [2:0]  ack_cnt;
    logic [15:0] img_offset;

    t_result expected_results[$];

    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int fails         = 0;
    int results_seen  = 0;
    int words_sent    = 0;
    int words_live    = 0;
    int transfers_done = 0;
    int restarts      = 0;
    int quiet_cycles  = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic void queue_result(input logic [1:0] kind, input logic [7:0] value,
                                         input logic [15:0] offset);
        t_result r;
        r.kind   = kind;
        r.value  = value;
        r.offset = offset;
        r.last   = 1'b0;
        expected_results.push_back(r);
    endfunction

    // Next read command for the remaining file, or the done word when nothing is left.
    function automatic void issue_read();
        logic [15:0]  cb;
        logic [15:0]  len;
        logic [127:0] cmd;
        cb = (cfg_chunk_bytes == 16'd0) ? 16'd1 : cfg_chunk_bytes;
        if (file_left == 16'd0) begin
            rd_phase = RD_IDLE;
            transfers_done++;
            queue_result(cjr_pkg::KIND_DONE, cjr_pkg::ZERO_BYTE, 16'd0);
            return;
        end
        len = (file_left < cb) ? file_left : cb;
        cmd = {cjr_pkg::CMD_SYNC, cjr_pkg::CMD_SERNO, cjr_pkg::CMD_READ, cjr_pkg::CMD_LEN,
               cjr_pkg::ZERO_BYTE, cjr_pkg::CMD_MODE, cjr_pkg::ZERO_BYTE, cjr_pkg::ZERO_BYTE,
               rd_addr[15:8], rd_addr[7:0], cjr_pkg::ZERO_BYTE, cjr_pkg::ZERO_BYTE,
               len[15:8], len[7:0], cjr_pkg::ZERO_BYTE, cjr_pkg::CMD_DELAY};
        for (int i = 0; i < 16; i++)
            queue_result(cjr_pkg::KIND_CMD, cmd[127 - 8 * i -: 8], 16'd0);
        rd_addr    = rd_addr + len;
        chunk_len  = len;
        chunk_left = len;
        ack_cnt    = 3'd0;
        rd_phase   = RD_ACK1;
    endfunction

    // Acknowledge hunt; a mismatching byte is retried as a first acknowledge byte.
    function automatic bit ack_hunt(input logic [7:0] b);
        logic [2:0] pos;
        pos = (ack_cnt < cjr_pkg::ACK_LENGTH) ? ack_cnt : 3'd0;
        if (b == ACK_WORD[8 * (4 - int'(pos)) +: 8])
            ack_cnt = pos + 3'd1;
        else
            ack_cnt = (b == cjr_pkg::ACK_FIRST) ? 3'd1 : 3'd0;
        if (ack_cnt >= cjr_pkg::ACK_LENGTH) begin
            ack_cnt = 3'd0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Expected results of one accepted input word.
    function automatic void predict_word(input logic op, input logic [7:0] b);
        int      first;
        t_result r;
        first = expected_results.size();
        if (op == cjr_pkg::OP_START || rd_phase != RD_IDLE)
            words_live++;
        if (op == cjr_pkg::OP_START) begin
            if (rd_phase != RD_IDLE)
                restarts++;
            file_left  = cfg_file_size;
            img_offset = 16'd0;
            ack_cnt    = 3'd0;
            issue_read();
        end else begin
            case (rd_phase)
                RD_ACK1: begin
                    if (ack_hunt(b))
                        rd_phase = RD_DATA;
                end
                RD_DATA: begin
                    queue_result(cjr_pkg::KIND_IMG, b, img_offset);
                    img_offset = img_offset + 16'd1;
                    if (file_left != 16'd0)
                        file_left = file_left - 16'd1;
                    if (chunk_left != 16'd0)
                        chunk_left = chunk_left - 16'd1;
                    if (chunk_left == 16'd0) begin
                        ack_cnt  = 3'd0;
                        rd_phase = RD_ACK2;
                    end
                end
                RD_ACK2: begin
                    if (ack_hunt(b))
                        issue_read();
                end
                default: rd_phase = RD_IDLE;
            endcase
        end
        // Flag the final result of this word.
        if (expected_results.size() > first) begin
            r = expected_results.pop_back();
            r.last = 1'b1;
            expected_results.push_back(r);
        end
    endfunction

    // Sends one word, with random idle cycles ahead of it, and predicts on acceptance.
    task automatic send_word(input logic op, input logic [7:0] b);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.rx_byte   <= b;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        words_sent++;
        predict_word(op, b);
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_word(cjr_pkg::OP_BYTE, bytes[i]);
    endtask

    // Drops valid and waits until every expected result has arrived and the block settles.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both registers; only called while the block is drained.
    task automatic write_config(input logic [15:0] fsize, input logic [15:0] cbytes);
        cfg_we    <= 1'b1;
        cfg_index <= cjr_pkg::CFG_FILE_SIZE;
        cfg_data  <= fsize;
        @(posedge i_clk);
        cfg_file_size = fsize;
        cfg_index <= cjr_pkg::CFG_CHUNK_BYTES;
        cfg_data  <= cbytes;
        @(posedge i_clk);
        cfg_chunk_bytes = cbytes;
        cfg_we <= 1'b0;
    endtask

    // A stray byte before any transfer is ignored; a start on an empty file gives done.
    task automatic test_idle_byte_and_empty_file();
        send_word(cjr_pkg::OP_BYTE, 8'hFF);
        send_word(cjr_pkg::OP_START, 8'h00);
        wait_drained();
    endtask

    // One-byte file with zero chunk size, a broken acknowledge, then the done word.
    task automatic test_single_byte_transfer();
        write_config(16'd1, 16'd0);
        send_word(cjr_pkg::OP_START, 8'hFF);
        send_bytes('{cjr_pkg::ACK_FIRST, cjr_pkg::ZERO_BYTE, cjr_pkg::ACK_FIRST,
                     cjr_pkg::ZERO_BYTE, cjr_pkg::CMD_READ, cjr_pkg::ZERO_BYTE,
                     cjr_pkg::ZERO_BYTE});
        send_word(cjr_pkg::OP_BYTE, 8'hFF);
        send_bytes('{cjr_pkg::ACK_FIRST, cjr_pkg::ZERO_BYTE, cjr_pkg::CMD_READ,
                     cjr_pkg::ZERO_BYTE, cjr_pkg::ZERO_BYTE});
        wait_drained();
    endtask

    // Largest sizes: the read address wraps, and a start in mid-hunt restarts the transfer.
    task automatic test_restart_and_address_wrap();
        write_config(16'hFFFF, 16'hFFFF);
        send_word(cjr_pkg::OP_START, 8'h5A);
        send_bytes('{cjr_pkg::ACK_FIRST, cjr_pkg::ZERO_BYTE});
        send_word(cjr_pkg::OP_START, 8'hA5);
        wait_drained();
    endtask

    // One random transfer: mostly well-formed acknowledges and data, some noise and restarts.
    task automatic run_transfer(input int word_end);
        logic [15:0] fsize;
        logic [15:0] cbytes;
        logic [7:0]  b;
        int          cap;
        case ($urandom_range(0, 9))
            0: begin
                fsize  = 16'($urandom);
                cbytes = 16'($urandom);
                cap    = 48;
            end
            1: begin
                fsize  = 16'd0;
                cbytes = 16'($urandom_range(0, 8));
                cap    = 4;
            end
            2: begin
                fsize  = 16'($urandom);
                cbytes = 16'($urandom_range(0, 4));
                cap    = 60;
            end
            default: begin
                fsize  = 16'($urandom_range(1, 24));
                cbytes = 16'($urandom_range(0, 12));
                cap    = 200;
            end
        endcase
        wait_drained();
        write_config(fsize, cbytes);
        if (rd_phase == RD_IDLE && $urandom_range(0, 3) == 0)
            send_word(cjr_pkg::OP_BYTE, 8'($urandom));
        send_word(cjr_pkg::OP_START, 8'($urandom));
        for (int n = 1; rd_phase != RD_IDLE && n < cap && words_live < word_end; n++) begin
            if ($urandom_range(0, 59) == 0) begin
                send_word(cjr_pkg::OP_START, 8'($urandom));
            end else if (rd_phase == RD_DATA) begin
                send_word(cjr_pkg::OP_BYTE, 8'($urandom));
            end else begin
                if ($urandom_range(0, 99) < 88)
                    b = ACK_WORD[8 * (4 - int'(ack_cnt)) +: 8];
                else if ($urandom_range(0, 1) == 0)
                    b = cjr_pkg::ACK_FIRST;
                else
                    b = 8'($urandom);
                send_word(cjr_pkg::OP_BYTE, b);
            end
        end
    endtask

    // Random transfers under one pacing of sender and receiver.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int word_end;
        wait_drained();
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        word_end      = words_live + PHASE_WORDS;
        while (words_live < word_end)
            run_transfer(word_end);
    endtask

    // Receiver: random stalls at the configured rate.
    always @(posedge i_clk)
        out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            fails++;
        end
    endfunction

    // Each accepted result word is compared with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual kind %0h byte %0h",
                         $time, out_ch.kind, out_ch.byte_value);
                fails++;
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 16'(want.kind), 16'(out_ch.kind));
                check_field("byte_value", 16'(want.value), 16'(out_ch.byte_value));
                check_field("image_offset", want.offset, out_ch.image_offset);
                check_field("last", 16'(want.last), 16'(out_ch.last));
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any accepted word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time,
                     expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= cjr_pkg::CFG_FILE_SIZE;
        cfg_data        <= 16'd0;
        in_ch.valid     <= 1'b0;
        in_ch.operation <= cjr_pkg::OP_START;
        in_ch.rx_byte   <= 8'd0;

        // Predictor starts from the reset state.
        cfg_file_size   = cjr_pkg::FILE_SIZE_RESET;
        cfg_chunk_bytes = cjr_pkg::CHUNK_BYTES_RESET;
        rd_phase        = RD_IDLE;
        rd_addr         = 16'd0;
        file_left       = 16'd0;
        chunk_left      = 16'd0;
        chunk_len       = 16'd0;
        ack_cnt         = 3'd0;
        img_offset      = 16'd0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_byte_and_empty_file();
        test_single_byte_transfer();
        test_restart_and_address_wrap();
        test_random_traffic(0, 0);
        test_random_traffic(54, 0);
        test_random_traffic(0, 54);
        test_random_traffic(24, 24);
        wait_drained();

        $display("Sent %0d input words, checked %0d results, %0d transfers done, %0d restarts.",
                 words_sent, results_seen, transfers_done, restarts);
        $display("Pacing covered full rate, sender gaps, receiver stalls and both together.");
        if (fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
